@@ hw/rtl/kwm_pkg.sv @@
`timescale 1ns / 1ps

package kwm_pkg;

    // Default sizes handed down from the top level.
    localparam int NUM_WAYS_DEF   = 4;
    localparam int FIFO_DEPTH_DEF = 16;

    // Fixed field widths of the channels and the register.
    localparam int WAY_FIELD_W = 2;
    localparam int VALUE_W     = 32;
    localparam int CFG_W       = 3;

    localparam logic [CFG_W-1:0] ACTIVE_WAYS_RST = 3'd4;

    // Longest run of results that one request may cause before emission pauses.
    localparam int MAX_RESULTS = 64;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [WAY_FIELD_W-1:0]    way;
        logic signed [VALUE_W-1:0] value;
        logic                      has_value;
        logic                      stream_end;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic                      value_valid;
        logic                      last;
        logic                      dropped;
    } result_t;

endpackage

@@ hw/rtl/kwm_in_if.sv @@
`timescale 1ns / 1ps

interface kwm_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [kwm_pkg::WAY_FIELD_W-1:0]           way;
    logic signed [kwm_pkg::VALUE_W-1:0]        value;
    logic                                      has_value;
    logic                                      stream_end;

    modport source (output valid, way, value, has_value, stream_end, input ready);
    modport sink (input valid, way, value, has_value, stream_end, output ready);
endinterface

@@ hw/rtl/kwm_out_if.sv @@
`timescale 1ns / 1ps

interface kwm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [kwm_pkg::VALUE_W-1:0] merged_value;
    logic                               value_valid;
    logic                               last;
    logic                               dropped;

    modport source (output valid, merged_value, value_valid, last, dropped, input ready);
    modport sink (input valid, merged_value, value_valid, last, dropped, output ready);
endinterface

@@ hw/rtl/kwm_ram.sv @@
`timescale 1ns / 1ps

module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/kwm_front.sv @@
`timescale 1ns / 1ps

module kwm_front #(
    parameter int NUM_WAYS = kwm_pkg::NUM_WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [kwm_pkg::CFG_W-1:0]     cfg_wr_data,
    kwm_in_if.sink                        items,
    output logic                          push_valid,
    input  logic                          push_ready,
    output kwm_pkg::item_t                push_data,
    output logic [$clog2(NUM_WAYS+1)-1:0] eff_ways
);

    localparam int CNT_W = $clog2(NUM_WAYS + 1);

    logic [kwm_pkg::CFG_W-1:0] active_ways_reg;
    logic                      way_active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_ways_reg <= kwm_pkg::ACTIVE_WAYS_RST;
        end
        else if (cfg_wr_en)
        begin
            active_ways_reg <= cfg_wr_data;
        end
    end

    // A register value above the number of ways built acts as that number.
    assign eff_ways = (32'(active_ways_reg) > NUM_WAYS) ? CNT_W'(NUM_WAYS)
                                                        : CNT_W'(active_ways_reg);

    // Requests for ways outside the job are taken and dropped here.
    assign way_active = 32'(items.way) < 32'(eff_ways);

    assign items.ready = push_ready;
    assign push_valid  = items.valid && way_active;

    assign push_data.way        = items.way;
    assign push_data.value      = items.value;
    assign push_data.has_value  = items.has_value;
    assign push_data.stream_end = items.stream_end;

endmodule

@@ hw/rtl/kwm_queue.sv @@
`timescale 1ns / 1ps

module kwm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  kwm_pkg::item_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output kwm_pkg::item_t pop_data
);

    localparam int DEPTH = kwm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kwm_pkg::item_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/kwm_back.sv @@
`timescale 1ns / 1ps

module kwm_back #(
    parameter int NUM_WAYS   = kwm_pkg::NUM_WAYS_DEF,
    parameter int FIFO_DEPTH = kwm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_clear,
    input  logic [$clog2(NUM_WAYS+1)-1:0] eff_ways,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  kwm_pkg::item_t                pop_data,
    kwm_out_if.source                     merged
);

    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int CNT_W     = $clog2(NUM_WAYS + 1);
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FILL_W    = $clog2(FIFO_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_WAYS * FIFO_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int RES_W     = $clog2(kwm_pkg::MAX_RESULTS + 1);
    localparam int VALUE_W   = kwm_pkg::VALUE_W;

    localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(FIFO_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t                    state_reg;
    logic [FILL_W-1:0]         fill_reg [NUM_WAYS];
    logic [PTR_W-1:0]          rp_reg [NUM_WAYS];
    logic [PTR_W-1:0]          wp_reg [NUM_WAYS];
    logic [NUM_WAYS-1:0]       fin_reg;
    logic [CNT_W-1:0]          scan_idx_reg;
    logic                      pend_reg;
    logic [WAY_W-1:0]          pend_way_reg;
    logic                      best_found_reg;
    logic [WAY_W-1:0]          best_way_reg;
    logic signed [VALUE_W-1:0] best_val_reg;
    logic [RES_W-1:0]          step_cnt_reg;
    logic                      out_valid_reg;
    kwm_pkg::result_t          out_data_reg;

    logic [WAY_W-1:0]   in_way;
    logic [WAY_W-1:0]   scan_way;
    logic               out_free;
    logic               blocked;
    logic               done;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    logic signed [VALUE_W-1:0] head_val;

    assign in_way   = WAY_W'(pop_data.way);
    assign scan_way = scan_idx_reg[WAY_W-1:0];
    assign out_free = !out_valid_reg || merged.ready;
    assign head_val = $signed(ram_rdata);

    // A way blocks emission while it is in the job, empty and not yet ended.
    // The job is done after a pop when every way in the job is ended and empty.
    always_comb
    begin
        blocked = 1'b0;
        done    = 1'b1;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (i < int'(eff_ways))
            begin
                if (fill_reg[i] == '0 && !fin_reg[i])
                begin
                    blocked = 1'b1;
                end
                if (WAY_W'(i) == best_way_reg)
                begin
                    if (!(fill_reg[i] == FILL_W'(1) && fin_reg[i]))
                    begin
                        done = 1'b0;
                    end
                end
                else if (!(fill_reg[i] == '0 && fin_reg[i]))
                begin
                    done = 1'b0;
                end
            end
        end
    end

    assign pop_ready = (state_reg == ST_IDLE) && out_free;

    assign ram_we    = pop_valid && pop_ready && !fin_reg[in_way] && pop_data.has_value
                       && (fill_reg[in_way] != FILL_W'(FIFO_DEPTH));
    assign ram_waddr = ADDR_W'(in_way) * DEPTH_A + ADDR_W'(wp_reg[in_way]);
    assign ram_re    = (state_reg == ST_SCAN) && (scan_idx_reg < eff_ways);
    assign ram_raddr = ADDR_W'(scan_way) * DEPTH_A + ADDR_W'(rp_reg[scan_way]);

    kwm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (RAM_DEPTH)
    ) u_buf (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (pop_data.value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign merged.valid        = out_valid_reg;
    assign merged.merged_value = out_data_reg.merged_value;
    assign merged.value_valid  = out_data_reg.value_valid;
    assign merged.last         = out_data_reg.last;
    assign merged.dropped      = out_data_reg.dropped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fin_reg        <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            pend_way_reg   <= '0;
            best_found_reg <= 1'b0;
            best_way_reg   <= '0;
            best_val_reg   <= '0;
            step_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                fill_reg[i] <= '0;
                rp_reg[i]   <= '0;
                wp_reg[i]   <= '0;
            end
        end
        else
        begin
            if (merged.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (job_clear)
            begin
                state_reg <= ST_IDLE;
                fin_reg   <= '0;
                for (int i = 0; i < NUM_WAYS; i++)
                begin
                    fill_reg[i] <= '0;
                    rp_reg[i]   <= '0;
                    wp_reg[i]   <= '0;
                end
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (pop_valid && pop_ready && !fin_reg[in_way])
                        begin
                            step_cnt_reg   <= '0;
                            scan_idx_reg   <= '0;
                            pend_reg       <= 1'b0;
                            best_found_reg <= 1'b0;
                            state_reg      <= ST_SCAN;
                            if (pop_data.has_value)
                            begin
                                if (fill_reg[in_way] == FILL_W'(FIFO_DEPTH))
                                begin
                                    out_valid_reg              <= 1'b1;
                                    out_data_reg.merged_value  <= '0;
                                    out_data_reg.value_valid   <= 1'b0;
                                    out_data_reg.last          <= 1'b0;
                                    out_data_reg.dropped       <= 1'b1;
                                    step_cnt_reg               <= RES_W'(1);
                                end
                                else
                                begin
                                    fill_reg[in_way] <= fill_reg[in_way] + FILL_W'(1);
                                    wp_reg[in_way]   <= (wp_reg[in_way] == PTR_W'(FIFO_DEPTH - 1))
                                                        ? '0 : wp_reg[in_way] + PTR_W'(1);
                                end
                            end
                            if (pop_data.stream_end)
                            begin
                                fin_reg[in_way] <= 1'b1;
                            end
                        end
                    end

                    ST_SCAN:
                    begin
                        if (scan_idx_reg == '0 && blocked)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            pend_reg     <= ram_re && (fill_reg[scan_way] != '0);
                            pend_way_reg <= scan_way;
                            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                            // Strict compare keeps the lowest way on equal heads.
                            if (pend_reg && (!best_found_reg || head_val < best_val_reg))
                            begin
                                best_found_reg <= 1'b1;
                                best_way_reg   <= pend_way_reg;
                                best_val_reg   <= head_val;
                            end
                            if (scan_idx_reg == eff_ways)
                            begin
                                state_reg <= ST_DECIDE;
                            end
                        end
                    end

                    ST_DECIDE:
                    begin
                        if (out_free)
                        begin
                            out_valid_reg         <= 1'b1;
                            out_data_reg.dropped  <= 1'b0;
                            if (!best_found_reg)
                            begin
                                // Every way has ended with nothing left: close the job.
                                out_data_reg.merged_value <= '0;
                                out_data_reg.value_valid  <= 1'b0;
                                out_data_reg.last         <= 1'b1;
                                state_reg                 <= ST_IDLE;
                                fin_reg                   <= '0;
                                for (int i = 0; i < NUM_WAYS; i++)
                                begin
                                    fill_reg[i] <= '0;
                                    rp_reg[i]   <= '0;
                                    wp_reg[i]   <= '0;
                                end
                            end
                            else
                            begin
                                out_data_reg.merged_value <= best_val_reg;
                                out_data_reg.value_valid  <= 1'b1;
                                out_data_reg.last         <= done;
                                if (done)
                                begin
                                    state_reg <= ST_IDLE;
                                    fin_reg   <= '0;
                                    for (int i = 0; i < NUM_WAYS; i++)
                                    begin
                                        fill_reg[i] <= '0;
                                        rp_reg[i]   <= '0;
                                        wp_reg[i]   <= '0;
                                    end
                                end
                                else
                                begin
                                    fill_reg[best_way_reg] <= fill_reg[best_way_reg] - FILL_W'(1);
                                    rp_reg[best_way_reg]   <=
                                        (rp_reg[best_way_reg] == PTR_W'(FIFO_DEPTH - 1))
                                        ? '0 : rp_reg[best_way_reg] + PTR_W'(1);
                                    step_cnt_reg   <= step_cnt_reg + RES_W'(1);
                                    scan_idx_reg   <= '0;
                                    pend_reg       <= 1'b0;
                                    best_found_reg <= 1'b0;
                                    if (step_cnt_reg + RES_W'(1) == RES_W'(kwm_pkg::MAX_RESULTS))
                                    begin
                                        state_reg <= ST_IDLE;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_SCAN;
                                    end
                                end
                            end
                        end
                    end

                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/k_way_sorted_merge.sv @@
`timescale 1ns / 1ps

// K-way sorted merge. Requests arrive on the items channel (valid/ready), each naming a
// way and carrying an optional value and an optional end-of-stream mark. Merged results
// leave on the merged channel (valid/ready) in ascending order, the final value of a job
// flagged with last; a job without values closes with one empty result carrying last,
// and a value for a full way buffer is reported once with dropped set.
// The user must write the active_ways register through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block does not enforce it. A write also clears the job in progress.
// A request passes the input queue and is applied in the idle state; then each
// merged result takes a head search of the active ways (scan, then decide), because the way
// heads are read one per cycle from the single-read-port buffer memory. A request that
// releases no result holds the back for the scan state only. One request is worked on
// at a time while the next waits in the two-entry queue.
// Reset clears the way buffers' counts, pointers and end flags and sets active_ways to
// four; no clearing pass is needed. When the receiver stalls, the finished result waits
// in the output register, the search holds, and the input queue fills and then drops ready.
module k_way_sorted_merge #(
    parameter int NUM_WAYS   = kwm_pkg::NUM_WAYS_DEF,
    parameter int FIFO_DEPTH = kwm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [kwm_pkg::CFG_W-1:0] cfg_wr_data,
    kwm_in_if.sink                    items,
    kwm_out_if.source                 merged
);

    localparam int CNT_W = $clog2(NUM_WAYS + 1);

    // Requests for active ways travel from the front to the back through this queue.
    logic           push_valid;
    logic           push_ready;
    kwm_pkg::item_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    kwm_pkg::item_t pop_data;

    logic [CNT_W-1:0] eff_ways;

    // The front holds the register and filters out requests for ways outside the job.
    kwm_front #(
        .NUM_WAYS (NUM_WAYS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .items       (items),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data),
        .eff_ways    (eff_ways)
    );

    kwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The back owns the way buffers, runs the head search and drives the output register.
    kwm_back #(
        .NUM_WAYS   (NUM_WAYS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_clear (cfg_wr_en),
        .eff_ways  (eff_ways),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .merged    (merged)
    );

endmodule

@@ bench/tb_k_way_sorted_merge.sv @@
`timescale 1ns / 1ps

class merge_scoreboard;

    logic signed [kwm_pkg::VALUE_W-1:0]
        slot [kwm_pkg::NUM_WAYS_DEF][kwm_pkg::FIFO_DEPTH_DEF];
    int unsigned head [kwm_pkg::NUM_WAYS_DEF];
    int unsigned fill [kwm_pkg::NUM_WAYS_DEF];
    bit ended [kwm_pkg::NUM_WAYS_DEF];
    int unsigned ways_used;
    kwm_pkg::result_t pending_results[$];
    int failures;
    int checked;
    int values_out;
    int drops_out;
    int markers_out;

    function new();
        ways_used = kwm_pkg::ACTIVE_WAYS_RST;
        failures = 0;
        checked = 0;
        values_out = 0;
        drops_out = 0;
        markers_out = 0;
        clear_job();
    endfunction

    function void clear_job();
        for (int i = 0; i < kwm_pkg::NUM_WAYS_DEF; i++)
        begin
            head[i] = 0;
            fill[i] = 0;
            ended[i] = 1'b0;
        end
    endfunction

    // Settings above the number of ways built act as all ways; a write also
    // abandons the job in progress.
    function void set_ways(logic [kwm_pkg::CFG_W-1:0] v);
        ways_used = (v > kwm_pkg::NUM_WAYS_DEF) ? kwm_pkg::NUM_WAYS_DEF : v;
        clear_job();
    endfunction

    function void add_result(logic signed [kwm_pkg::VALUE_W-1:0] v, logic vv,
                             logic lst, logic drp);
        kwm_pkg::result_t r;
        r.merged_value = v;
        r.value_valid = vv;
        r.last = lst;
        r.dropped = drp;
        pending_results.push_back(r);
    endfunction

    // Applies one accepted request and queues the results it releases.
    // Returns 0 when the request is ignored by the block.
    function bit note_request(kwm_pkg::item_t it);
        int cnt;
        int best;
        bit blocked;
        bit done;
        logic signed [kwm_pkg::VALUE_W-1:0] best_v;
        cnt = 0;
        if (it.way >= ways_used || ended[it.way])
            return 1'b0;
        if (it.has_value)
        begin
            if (fill[it.way] >= kwm_pkg::FIFO_DEPTH_DEF)
            begin
                add_result('0, 1'b0, 1'b0, 1'b1);
                cnt++;
            end
            else
            begin
                slot[it.way][(head[it.way] + fill[it.way]) % kwm_pkg::FIFO_DEPTH_DEF] =
                    it.value;
                fill[it.way]++;
            end
        end
        if (it.stream_end)
            ended[it.way] = 1'b1;
        while (cnt < kwm_pkg::MAX_RESULTS)
        begin
            blocked = 1'b0;
            best = -1;
            best_v = '0;
            for (int i = 0; i < ways_used; i++)
            begin
                if (fill[i] == 0)
                begin
                    if (!ended[i])
                        blocked = 1'b1;
                end
                else if (best < 0 || slot[i][head[i]] < best_v)
                begin
                    best = i;
                    best_v = slot[i][head[i]];
                end
            end
            if (blocked)
                break;
            if (best < 0)
            begin
                add_result('0, 1'b0, 1'b1, 1'b0);
                cnt++;
                clear_job();
                break;
            end
            head[best] = (head[best] + 1) % kwm_pkg::FIFO_DEPTH_DEF;
            fill[best]--;
            done = 1'b1;
            for (int i = 0; i < ways_used; i++)
                if (fill[i] != 0 || !ended[i])
                    done = 1'b0;
            add_result(best_v, 1'b1, done, 1'b0);
            cnt++;
            if (done)
            begin
                clear_job();
                break;
            end
        end
        return 1'b1;
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10)
            $display("ERROR: %s", msg);
    endfunction

    function void check_result(kwm_pkg::result_t got);
        kwm_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            flag($sformatf("unrequested result value=%0d valid=%b last=%b dropped=%b",
                           got.merged_value, got.value_valid, got.last, got.dropped));
            return;
        end
        want = pending_results.pop_front();
        checked++;
        if (want.dropped)
            drops_out++;
        else if (want.value_valid)
            values_out++;
        else
            markers_out++;
        if (got.merged_value !== want.merged_value || got.value_valid !== want.value_valid ||
            got.last !== want.last || got.dropped !== want.dropped)
            flag($sformatf({"result %0d: wanted value=%0d valid=%b last=%b dropped=%b, ",
                            "saw value=%0d valid=%b last=%b dropped=%b"}, checked,
                           want.merged_value, want.value_valid, want.last, want.dropped,
                           got.merged_value, got.value_valid, got.last, got.dropped));
    endfunction

    function void close_out();
        if (pending_results.size() != 0)
            flag($sformatf("%0d results never arrived", pending_results.size()));
    endfunction

endclass

module tb_k_way_sorted_merge;

    // Generous bound on the whole run; a correct run needs a small fraction of it.
    localparam int LIMIT = 300000;
    // Cycles allowed for requests that release no result to leave the block.
    localparam int SETTLE = 40;
    localparam int RANDOM_ITEMS = 180;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [kwm_pkg::CFG_W-1:0] cfg_wr_data;

    kwm_in_if items_if ();
    kwm_out_if merged_if ();

    merge_scoreboard sb;
    kwm_pkg::result_t seen;

    int send_idle;
    int recv_idle;
    int cycles = 0;
    int taken_items;
    int ignored_items;
    int jobs_run;
    bit [7:0] ways_seen;

    k_way_sorted_merge dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .items       (items_if),
        .merged      (merged_if)
    );

    always #6 clk = ~clk;

    // Watchdog: a hung handshake must not leave the run spinning for ever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver side. Every accepted result is checked against the oldest
    // outstanding prediction, and ready for the next cycle is drawn afresh so
    // that stalls land on every phase of the head search.
    always @(posedge clk)
    begin
        if (rst_n && merged_if.valid && merged_if.ready)
        begin
            seen.merged_value = merged_if.merged_value;
            seen.value_valid = merged_if.value_valid;
            seen.last = merged_if.last;
            seen.dropped = merged_if.dropped;
            sb.check_result(seen);
        end
        merged_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Presents one request, holding it until the block takes it. Valid stays
    // high straight into the next request unless an idle gap is drawn.
    task automatic offer_request(input kwm_pkg::item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            items_if.valid <= 1'b0;
            @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.way <= it.way;
        items_if.value <= it.value;
        items_if.has_value <= it.has_value;
        items_if.stream_end <= it.stream_end;
        do
            @(posedge clk);
        while (!items_if.ready);
        if (sb.note_request(it))
            taken_items++;
        else
            ignored_items++;
    endtask

    task automatic push_item(input int w, input logic [kwm_pkg::VALUE_W-1:0] v, input bit hv,
                             input bit fin);
        kwm_pkg::item_t it;
        it.way = w[kwm_pkg::WAY_FIELD_W-1:0];
        it.value = v;
        it.has_value = hv;
        it.stream_end = fin;
        offer_request(it);
    endtask

    // The register may only change while the block is idle, so every
    // outstanding result is collected first and the input queue is given time
    // to empty of requests that release nothing.
    task automatic set_active_ways(input logic [kwm_pkg::CFG_W-1:0] v);
        items_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_ways(v);
        ways_seen[v] = 1'b1;
    endtask

    // One merge job over n ways. Each way gets an ascending run of values and
    // an end mark, either on its final value or as a request of its own. The
    // ways are interleaved at random, except in a heavy job, where one long way
    // is sent in full before the others so that its buffer can overflow. Noise
    // requests with random fields may hit inactive or finished ways or break
    // the job off half way.
    task automatic run_job(input int n, input bit heavy, input int noise_pct);
        kwm_pkg::item_t plan[$];
        kwm_pkg::item_t it;
        int vals[$];
        int prev;
        int pos;
        int len;
        int w;
        int first_way;
        int spread;
        bit end_on_value;
        logic [31:0] rnd;
        first_way = $urandom_range(n - 1);
        spread = $urandom_range(2);
        for (int j = 0; j < n; j++)
        begin
            w = (first_way + j) % n;
            vals.delete();
            len = (heavy && j == 0) ? $urandom_range(14, 22) : $urandom_range(0, 5);
            for (int k = 0; k < len; k++)
            begin
                if (spread == 0)
                    vals.push_back(int'($urandom));
                else if (spread == 1)
                    vals.push_back(int'($urandom_range(0, 8)) - 4);
                else
                    vals.push_back(($urandom_range(1) != 0) ? 32'h7fff_fff0 + int'($urandom_range(15))
                                                            : 32'h8000_0000 + int'($urandom_range(15)));
            end
            vals.sort();
            end_on_value = (len > 0) && ($urandom_range(1) != 0);
            prev = -1;
            for (int k = 0; k <= len; k++)
            begin
                it.way = w[kwm_pkg::WAY_FIELD_W-1:0];
                if (k < len)
                begin
                    it.value = vals[k];
                    it.has_value = 1'b1;
                    it.stream_end = end_on_value && (k == len - 1);
                end
                else
                begin
                    if (end_on_value)
                        break;
                    it.value = $urandom;
                    it.has_value = 1'b0;
                    it.stream_end = 1'b1;
                end
                if (heavy)
                    plan.push_back(it);
                else
                begin
                    pos = $urandom_range(prev + 1, plan.size());
                    plan.insert(pos, it);
                    prev = pos;
                end
            end
        end
        if ($urandom_range(99) < noise_pct)
        begin
            repeat ($urandom_range(1, 3))
            begin
                rnd = $urandom;
                it.way = rnd[kwm_pkg::WAY_FIELD_W-1:0];
                it.value = $urandom;
                it.has_value = rnd[8];
                it.stream_end = rnd[9];
                plan.insert($urandom_range(plan.size()), it);
            end
        end
        foreach (plan[i])
            offer_request(plan[i]);
        jobs_run++;
    endtask

    initial
    begin
        logic [kwm_pkg::CFG_W-1:0] cfg_order[$];
        logic [kwm_pkg::CFG_W-1:0] v;
        logic [31:0] rnd;
        int base;
        int progress;
        int n;

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        items_if.valid = 1'b0;
        items_if.way = '0;
        items_if.value = '0;
        items_if.has_value = 1'b0;
        items_if.stream_end = 1'b0;
        taken_items = 0;
        ignored_items = 0;
        jobs_run = 0;
        ways_seen = '0;
        send_idle = 12;
        recv_idle = 52;
        sb = new();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Four ways from reset. The smallest and largest values meet equal
        // heads on three ways, which must go out lowest way first; a request for
        // a way that has already ended is ignored.
        push_item(0, 32'h8000_0000, 1'b1, 1'b0);
        push_item(1, 32'h7fff_ffff, 1'b1, 1'b1);
        push_item(1, 32'h0000_0003, 1'b1, 1'b0);
        push_item(2, 5, 1'b1, 1'b0);
        push_item(3, 5, 1'b1, 1'b1);
        push_item(0, 5, 1'b1, 1'b1);
        push_item(2, $urandom, 1'b0, 1'b1);

        // One way that ends without any value closes with an empty marker; a
        // request for a way beyond the active count is ignored.
        set_active_ways(3'd1);
        push_item(2, $urandom, 1'b1, 1'b1);
        push_item(0, $urandom, 1'b0, 1'b1);

        // No active ways: everything is ignored.
        set_active_ways(3'd0);
        push_item(0, 32'h0000_0001, 1'b1, 1'b1);
        push_item(3, 32'hffff_ffff, 1'b1, 1'b0);

        // The final end mark arrives after way 0's last value has left and
        // releases way 1's value, which closes the job with last set.
        set_active_ways(3'd2);
        push_item(0, 10, 1'b1, 1'b0);
        push_item(1, 20, 1'b1, 1'b1);
        push_item(0, $urandom, 1'b0, 1'b1);

        // Way 1 is sent seventeen values while way 0 holds nothing: the last
        // one overflows the buffer and is reported as dropped, yet its end mark
        // still counts.
        for (int k = 0; k < 17; k++)
            push_item(1, 3 * k - 20, 1'b1, k == 16);
        push_item(0, $urandom, 1'b0, 1'b1);

        // Random jobs. The first register writes walk through every setting,
        // the largest first; later ones are drawn at random.
        cfg_order = '{3'd7, 3'd3, 3'd5, 3'd4, 3'd6, 3'd1, 3'd2, 3'd0};
        base = taken_items;
        progress = 0;
        while (progress < RANDOM_ITEMS)
        begin
            if (progress < RANDOM_ITEMS / 3)
            begin
                send_idle = 12;
                recv_idle = 52;
            end
            else if (progress < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 52;
                recv_idle = 12;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (cfg_order.size() != 0 || sb.ways_used == 0 || $urandom_range(2) == 0)
            begin
                rnd = $urandom;
                v = (cfg_order.size() != 0) ? cfg_order.pop_front() : rnd[kwm_pkg::CFG_W-1:0];
                set_active_ways(v);
            end
            n = sb.ways_used;
            if (n == 0)
            begin
                repeat (3)
                begin
                    rnd = $urandom;
                    push_item(int'(rnd[kwm_pkg::WAY_FIELD_W-1:0]), $urandom, rnd[8], rnd[9]);
                end
            end
            else
                run_job(n, $urandom_range(4) == 0, 15);
            progress = taken_items - base;
        end

        items_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        sb.close_out();

        $display("Summary: %0d requests merged and %0d ignored over %0d random jobs; %0d results",
                 taken_items, ignored_items, jobs_run, sb.checked);
        $display("checked (%0d values, %0d drop reports, %0d end markers), settings used %b.",
                 sb.values_out, sb.drops_out, sb.markers_out, ways_seen);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d failures in total.", sb.failures);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
